// ===== rtl/tlpg_pkg.sv =====
package tlpg_pkg;

	localparam int COORD_BITS    = 10;
	localparam int MAX_THICKNESS = 31;

	// fixed field widths
	localparam int IN_COORD_W = 10;
	localparam int THICK_W    = 5;
	localparam int COLOUR_W   = 8;
	localparam int OUT_W      = 12;

	localparam int CW     = COORD_BITS;
	// minor coordinate range: base (coord + offset) plus up to one full minor delta
	localparam int QW     = COORD_BITS + 3;
	localparam int PASS_W = $clog2(MAX_THICKNESS + 1);

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef struct packed {
		logic                  busy;
		logic                  steep;
		logic [CW-1:0]         major_start;
		logic [CW-1:0]         major_end;
		logic signed [QW-1:0]  pass_base;
		logic [CW-1:0]         d_abs;
		logic                  inc_neg;
		logic                  inc_full;
		logic [CW-1:0]         inc_rem;
		logic [PASS_W-1:0]     passes;
		logic [COLOUR_W-1:0]   colour;
	} line_setup_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] x;
		logic signed [OUT_W-1:0] y;
		logic [COLOUR_W-1:0]     colour;
		logic                    last;
	} pixel_t;

endpackage

// ===== rtl/tlpg_line_setup.sv =====
module tlpg_line_setup (
	input  logic [tlpg_pkg::IN_COORD_W-1:0] start_x,
	input  logic [tlpg_pkg::IN_COORD_W-1:0] start_y,
	input  logic [tlpg_pkg::IN_COORD_W-1:0] end_x,
	input  logic [tlpg_pkg::IN_COORD_W-1:0] end_y,
	input  logic [tlpg_pkg::COLOUR_W-1:0]   pen_colour,
	input  logic [tlpg_pkg::THICK_W-1:0]    thickness,
	output tlpg_pkg::line_setup_t           setup
);
	import tlpg_pkg::*;

	logic [CW-1:0]        x1, y1, x2, y2;
	logic signed [CW:0]   dx, dy, dmaj, dmin, inc;
	logic [CW-1:0]        adx, ady, a1, a2, b1;
	logic [PASS_W-1:0]    w;
	logic                 steep;
	logic signed [QW-1:0] b_ext, adj, half;

	always_comb begin
		x1 = CW'(start_x);
		y1 = CW'(start_y);
		x2 = CW'(end_x);
		y2 = CW'(end_y);
		dx = $signed({1'b0, x2}) - $signed({1'b0, x1});
		dy = $signed({1'b0, y2}) - $signed({1'b0, y1});
		adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];
		ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
		steep = !(dx != '0 && ady <= adx);

		if (!steep) begin
			a1 = x1; a2 = x2; b1 = y1; dmaj = dx; dmin = dy;
		end else begin
			a1 = y1; a2 = y2; b1 = x1; dmaj = dy; dmin = dx;
		end

		if (int'(thickness) > MAX_THICKNESS)
			w = PASS_W'(MAX_THICKNESS);
		else
			w = PASS_W'(thickness);

		setup.steep       = steep;
		setup.major_start = (a1 < a2) ? a1 : a2;
		setup.major_end   = (a1 < a2) ? a2 : a1;
		setup.d_abs       = dmaj[CW] ? CW'(-dmaj) : dmaj[CW-1:0];

		// work on the numerator scaled by sign(delta_major), so the divisor is positive
		inc = dmaj[CW] ? -dmin : dmin;
		setup.inc_full = (inc == $signed({1'b0, setup.d_abs}));
		setup.inc_neg  = inc[CW];
		if (setup.inc_full)
			setup.inc_rem = '0;
		else if (setup.inc_neg)
			setup.inc_rem = CW'(inc + $signed({1'b0, setup.d_abs}));
		else
			setup.inc_rem = inc[CW-1:0];

		// walking down from the far end starts one full minor delta away
		b_ext = $signed({3'b000, b1});
		adj   = (a1 > a2) ? QW'(dmin) : '0;
		half  = $signed(QW'(w >> 1));
		setup.pass_base = b_ext + adj + half;

		setup.passes = w;
		setup.colour = pen_colour;
		setup.busy   = (w != '0) && (setup.major_end > setup.major_start);
	end

endmodule

// ===== rtl/tlpg_stepper.sv =====
module tlpg_stepper (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic                  op,
	input  tlpg_pkg::line_setup_t setup,
	output logic                  push,
	output tlpg_pkg::pixel_t      pixel
);
	import tlpg_pkg::*;

	logic                 busy_q, steep_q;
	logic [CW-1:0]        major_pos_q, major_start_q, major_end_q;
	logic signed [QW-1:0] pass_base_q, quot_q;
	logic [CW-1:0]        rem_q, d_abs_q, inc_rem_q;
	logic                 inc_neg_q, inc_full_q;
	logic [PASS_W-1:0]    passes_left_q;
	logic [COLOUR_W-1:0]  colour_q;

	logic                 step, pass_end, line_end, carry;
	logic signed [QW-1:0] quot_trunc, quot_delta, quot_n;
	logic [CW:0]          rem_sum;
	logic [CW-1:0]        rem_n, major_n;

	always_comb begin
		step = accept && (op == OP_STEP) && busy_q;
		push = step;

		// floor quotient to truncation toward zero
		quot_trunc = quot_q + $signed(QW'(quot_q[QW-1] && rem_q != '0));

		rem_sum = {1'b0, rem_q} + {1'b0, inc_rem_q};
		carry   = rem_sum >= {1'b0, d_abs_q};
		rem_n   = carry ? CW'(rem_sum - {1'b0, d_abs_q}) : rem_sum[CW-1:0];
		if (inc_full_q)
			quot_delta = QW'(1);
		else if (inc_neg_q)
			quot_delta = '1;
		else
			quot_delta = '0;
		quot_n = quot_q + quot_delta + $signed(QW'(carry));

		major_n  = major_pos_q + CW'(1);
		pass_end = (major_n >= major_end_q);
		line_end = pass_end && (passes_left_q == PASS_W'(1));

		pixel.x      = steep_q ? OUT_W'(quot_trunc) : OUT_W'(major_pos_q);
		pixel.y      = steep_q ? OUT_W'(major_pos_q) : OUT_W'(quot_trunc);
		pixel.colour = colour_q;
		pixel.last   = line_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept && op == OP_START) begin
			busy_q <= setup.busy;
		end else if (step && line_end) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && op == OP_START) begin
			steep_q       <= setup.steep;
			major_pos_q   <= setup.major_start;
			major_start_q <= setup.major_start;
			major_end_q   <= setup.major_end;
			pass_base_q   <= setup.pass_base;
			quot_q        <= setup.pass_base;
			rem_q         <= '0;
			d_abs_q       <= setup.d_abs;
			inc_neg_q     <= setup.inc_neg;
			inc_full_q    <= setup.inc_full;
			inc_rem_q     <= setup.inc_rem;
			passes_left_q <= setup.passes;
			colour_q      <= setup.colour;
		end else if (step) begin
			if (pass_end) begin
				// rewind to the start of the next pass, one row/column lower
				major_pos_q   <= major_start_q;
				pass_base_q   <= pass_base_q - QW'(1);
				quot_q        <= pass_base_q - QW'(1);
				rem_q         <= '0;
				passes_left_q <= passes_left_q - PASS_W'(1);
			end else begin
				major_pos_q <= major_n;
				quot_q      <= quot_n;
				rem_q       <= rem_n;
			end
		end
	end

endmodule

// ===== rtl/tlpg_out_buf.sv =====
module tlpg_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  tlpg_pkg::pixel_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output tlpg_pkg::pixel_t out_data
);
	import tlpg_pkg::*;

	logic   main_valid_q, skid_valid_q;
	pixel_t main_q, skid_q;
	logic   pop;

	assign pop       = main_valid_q && !out_stall;
	assign full      = skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (push) begin
			if (main_valid_q && !pop)
				skid_valid_q <= 1'b1;
			else
				main_valid_q <= 1'b1;
		end else if (pop) begin
			main_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop)
				main_q <= skid_q;
		end else if (push) begin
			if (main_valid_q && !pop)
				skid_q <= push_data;
			else
				main_q <= push_data;
		end
	end

endmodule

// ===== rtl/thick_line_pixel_generator.sv =====
// Thick line pixel generator. A start transaction (op = 0) loads both endpoints,
// the colour and the thickness and returns nothing; every step transaction (op = 1)
// then returns the next pixel of the line, one pixel per unstalled clock, drawn as
// 'thickness' parallel passes along the major axis with last_pixel set on the final
// one. A step with no line in progress returns nothing. The minor coordinate
// advances by one quotient/remainder add and compare per pixel, and a pixel shows on
// pixel_valid the cycle after its step is taken when no earlier pixel is still
// waiting at the port. A two-entry output buffer sits in front of the pixel port;
// item_stall rises only when both entries are held by a stalled consumer.
module thick_line_pixel_generator (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_stall,
	input  logic                                  op,
	input  logic [tlpg_pkg::IN_COORD_W-1:0]       start_x,
	input  logic [tlpg_pkg::IN_COORD_W-1:0]       start_y,
	input  logic [tlpg_pkg::IN_COORD_W-1:0]       end_x,
	input  logic [tlpg_pkg::IN_COORD_W-1:0]       end_y,
	input  logic [tlpg_pkg::COLOUR_W-1:0]         pen_colour,
	input  logic [tlpg_pkg::THICK_W-1:0]          thickness,
	output logic                                  pixel_valid,
	input  logic                                  pixel_stall,
	output logic signed [tlpg_pkg::OUT_W-1:0]     pixel_x,
	output logic signed [tlpg_pkg::OUT_W-1:0]     pixel_y,
	output logic [tlpg_pkg::COLOUR_W-1:0]         pixel_colour,
	output logic                                  last_pixel
);
	import tlpg_pkg::*;

	line_setup_t setup;
	pixel_t      step_pixel, out_pixel;
	logic        accept, push;

	assign accept = item_valid && !item_stall;

	tlpg_line_setup u_setup (
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.pen_colour (pen_colour),
		.thickness  (thickness),
		.setup      (setup)
	);

	tlpg_stepper u_stepper (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.op     (op),
		.setup  (setup),
		.push   (push),
		.pixel  (step_pixel)
	);

	tlpg_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (step_pixel),
		.full      (item_stall),
		.out_valid (pixel_valid),
		.out_stall (pixel_stall),
		.out_data  (out_pixel)
	);

	assign pixel_x      = out_pixel.x;
	assign pixel_y      = out_pixel.y;
	assign pixel_colour = out_pixel.colour;
	assign last_pixel   = out_pixel.last;

endmodule

// ===== rtl/tlpg_checker.sv =====
module tlpg_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_valid,
	input logic                              item_stall,
	input logic                              op,
	input logic [tlpg_pkg::IN_COORD_W-1:0]   start_x,
	input logic [tlpg_pkg::IN_COORD_W-1:0]   start_y,
	input logic [tlpg_pkg::IN_COORD_W-1:0]   end_x,
	input logic [tlpg_pkg::IN_COORD_W-1:0]   end_y,
	input logic [tlpg_pkg::COLOUR_W-1:0]     pen_colour,
	input logic [tlpg_pkg::THICK_W-1:0]      thickness,
	input logic                              pixel_valid,
	input logic                              pixel_stall,
	input logic signed [tlpg_pkg::OUT_W-1:0] pixel_x,
	input logic signed [tlpg_pkg::OUT_W-1:0] pixel_y,
	input logic [tlpg_pkg::COLOUR_W-1:0]     pixel_colour,
	input logic                              last_pixel
);
	import tlpg_pkg::*;

	// hold a stalled pixel transaction
	a_pixel_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid && pixel_stall |=> pixel_valid && $stable(pixel_x) &&
		$stable(pixel_y) && $stable(pixel_colour) && $stable(last_pixel))
		else $error("stalled pixel changed");

	// back-pressure only with a pixel waiting at the port
	a_stall_needs_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> pixel_valid)
		else $error("item_stall without pending pixel");

	// an empty port frees the input side in the next cycle
	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel_valid |=> !item_stall)
		else $error("item_stall one cycle after empty output");

	// a start transaction never produces a pixel
	a_start_silent: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && op == OP_START && !pixel_valid |=> !pixel_valid)
		else $error("pixel after start transaction");

endmodule

bind thick_line_pixel_generator tlpg_checker u_tlpg_checker (.*);

// ===== bench/line_pixel_checker.sv =====
`timescale 1ns / 100ps

module line_pixel_checker
	import tlpg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	input  logic                      item_stall,
	input  logic                      op,
	input  logic [IN_COORD_W-1:0]     start_x,
	input  logic [IN_COORD_W-1:0]     start_y,
	input  logic [IN_COORD_W-1:0]     end_x,
	input  logic [IN_COORD_W-1:0]     end_y,
	input  logic [COLOUR_W-1:0]       pen_colour,
	input  logic [THICK_W-1:0]        thickness,
	input  logic                      pixel_valid,
	input  logic                      pixel_stall,
	input  logic signed [OUT_W-1:0]   pixel_x,
	input  logic signed [OUT_W-1:0]   pixel_y,
	input  logic [COLOUR_W-1:0]       pixel_colour,
	input  logic                      last_pixel,
	output int                        pixels_pending,
	output int                        error_count
);

	pixel_t pixels_due[$];
	int pending_r = 0;
	int errors = 0;

	// line being traced
	logic busy = 1'b0;
	logic steep = 1'b0;
	int pos = 0;
	int pos_lo = 0;
	int pos_hi = 0;
	int anchor = 0;
	int minor0 = 0;
	int d_major = 0;
	int d_minor = 0;
	int offset = 0;
	int passes = 0;
	logic [COLOUR_W-1:0] colour = '0;

	assign pixels_pending = pending_r;
	assign error_count = errors;

	function automatic int coord(input logic [IN_COORD_W-1:0] v);
		return int'(v) % (1 << COORD_BITS);
	endfunction

	task automatic load_line(input int x1, input int y1, input int x2, input int y2,
			input int w, input logic [COLOUR_W-1:0] c);
		int dx;
		int dy;
		int a1;
		int a2;
		dx = x2 - x1;
		dy = y2 - y1;
		if (w > MAX_THICKNESS)
			w = MAX_THICKNESS;
		colour = c;
		steep = !(dx != 0 && (dy < 0 ? -dy : dy) <= (dx < 0 ? -dx : dx));
		if (!steep) begin
			a1 = x1;
			a2 = x2;
			minor0 = y1;
			d_major = dx;
			d_minor = dy;
		end else begin
			a1 = y1;
			a2 = y2;
			minor0 = x1;
			d_major = dy;
			d_minor = dx;
		end
		anchor = a1;
		pos_lo = (a1 < a2) ? a1 : a2;
		pos_hi = (a1 < a2) ? a2 : a1;
		pos = pos_lo;
		offset = w / 2;
		passes = w;
		busy = (w > 0) && (pos_hi > pos_lo) && (d_major != 0);
	endtask

	// exact quotient, truncated toward zero
	task automatic next_pixel(output pixel_t p);
		longint num;
		longint q;
		num = longint'(minor0 + offset) * d_major + longint'(d_minor) * (pos - anchor);
		q = num / d_major;
		if (!steep) begin
			p.x = pos[OUT_W-1:0];
			p.y = q[OUT_W-1:0];
		end else begin
			p.x = q[OUT_W-1:0];
			p.y = pos[OUT_W-1:0];
		end
		p.colour = colour;
		p.last = 1'b0;
		pos++;
		if (pos >= pos_hi) begin
			pos = pos_lo;
			offset--;
			passes--;
			if (passes <= 0) begin
				busy = 1'b0;
				p.last = 1'b1;
			end
		end
	endtask

	always @(posedge clk) begin : watch
		pixel_t got;
		pixel_t want;
		if (arst_n) begin
			if (pixel_valid && !pixel_stall) begin
				got.x = pixel_x;
				got.y = pixel_y;
				got.colour = pixel_colour;
				got.last = last_pixel;
				if (pixels_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: unexpected pixel x=%0d y=%0d colour=%0d last=%0b",
							$time, got.x, got.y, got.colour, got.last);
					errors++;
				end else begin
					want = pixels_due.pop_front();
					if (got.x !== want.x || got.y !== want.y ||
							got.colour !== want.colour || got.last !== want.last) begin
						if (errors < 10)
							$display({"%0t: pixel mismatch: expected x=%0d y=%0d colour=%0d ",
								"last=%0b, got x=%0d y=%0d colour=%0d last=%0b"}, $time,
								want.x, want.y, want.colour, want.last,
								got.x, got.y, got.colour, got.last);
						errors++;
					end
				end
			end
			if (item_valid && !item_stall) begin
				if (op == OP_START) begin
					load_line(coord(start_x), coord(start_y), coord(end_x), coord(end_y),
						int'(thickness), pen_colour);
				end else if (busy) begin
					next_pixel(want);
					pixels_due.push_back(want);
				end
			end
		end
		pending_r <= pixels_due.size();
	end

endmodule

// ===== bench/tb_thick_line_pixel_generator.sv =====
`timescale 1ns / 100ps

module tb_thick_line_pixel_generator;
	import tlpg_pkg::*;

	localparam int LINE_ITEMS  = 1200;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_stall;
	logic op = OP_STEP;
	logic [IN_COORD_W-1:0] start_x = '0;
	logic [IN_COORD_W-1:0] start_y = '0;
	logic [IN_COORD_W-1:0] end_x = '0;
	logic [IN_COORD_W-1:0] end_y = '0;
	logic [COLOUR_W-1:0] pen_colour = '0;
	logic [THICK_W-1:0] thickness = '0;
	logic pixel_valid;
	logic pixel_stall = 1'b0;
	logic signed [OUT_W-1:0] pixel_x;
	logic signed [OUT_W-1:0] pixel_y;
	logic [COLOUR_W-1:0] pixel_colour;
	logic last_pixel;

	int pixels_pending;
	int error_count;
	int wait_cap = 14;
	int line_items = 0;
	int cycle_count = 0;
	int unsigned stall_left = 0;

	thick_line_pixel_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.op           (op),
		.start_x      (start_x),
		.start_y      (start_y),
		.end_x        (end_x),
		.end_y        (end_y),
		.pen_colour   (pen_colour),
		.thickness    (thickness),
		.pixel_valid  (pixel_valid),
		.pixel_stall  (pixel_stall),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.pixel_colour (pixel_colour),
		.last_pixel   (last_pixel)
	);

	line_pixel_checker pixel_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.op             (op),
		.start_x        (start_x),
		.start_y        (start_y),
		.end_x          (end_x),
		.end_y          (end_y),
		.pen_colour     (pen_colour),
		.thickness      (thickness),
		.pixel_valid    (pixel_valid),
		.pixel_stall    (pixel_stall),
		.pixel_x        (pixel_x),
		.pixel_y        (pixel_y),
		.pixel_colour   (pixel_colour),
		.last_pixel     (last_pixel),
		.pixels_pending (pixels_pending),
		.error_count    (error_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_thick_line_pixel_generator: FAIL");
			$finish;
		end
	end

	function automatic int draw_wait();
		if (wait_cap == 0)
			return 0;
		case ($urandom_range(0, 3))
			0, 1: return 0;
			2: return $urandom_range(1, 3);
			default: return $urandom_range(0, wait_cap);
		endcase
	endfunction

	// hold off the pixel port for a fresh number of cycles after each transaction
	always @(posedge clk) begin
		if (pixel_valid && !pixel_stall)
			stall_left = draw_wait();
		else if (stall_left != 0)
			stall_left--;
		pixel_stall <= (stall_left != 0);
	end

	function automatic int pick_coord();
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(1020, 1023);
		return $urandom_range(0, 1023);
	endfunction

	function automatic int line_pixels(input int sx, input int sy, input int ex, input int ey,
			input int thk);
		int dx;
		int dy;
		dx = (ex > sx) ? ex - sx : sx - ex;
		dy = (ey > sy) ? ey - sy : sy - ey;
		if (dx != 0 && dy <= dx)
			return dx * thk;
		return dy * thk;
	endfunction

	// leave valid high on return so back-to-back items need no extra edge
	task automatic send_item(input logic kind, input int sx, input int sy, input int ex,
			input int ey, input int col, input int thk);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		op <= kind;
		start_x <= sx[IN_COORD_W-1:0];
		start_y <= sy[IN_COORD_W-1:0];
		end_x <= ex[IN_COORD_W-1:0];
		end_y <= ey[IN_COORD_W-1:0];
		pen_colour <= col[COLOUR_W-1:0];
		thickness <= thk[THICK_W-1:0];
		do @(posedge clk); while (item_stall);
	endtask

	task automatic step_line(input int n);
		repeat (n)
			send_item(OP_STEP, $urandom_range(0, 1023), $urandom_range(0, 1023),
				$urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(0, 255),
				$urandom_range(0, 31));
	endtask

	// start a line, then step it to the end plus extra idle steps, or cut it short
	task automatic run_line(input int sx, input int sy, input int ex, input int ey,
			input int col, input int thk, input int extra, input bit cut);
		int total;
		int n;
		total = line_pixels(sx, sy, ex, ey, thk);
		if (cut && total > 1)
			n = $urandom_range(1, (total - 1 < 3) ? total - 1 : 3);
		else
			n = total + extra;
		send_item(OP_START, sx, sy, ex, ey, col, thk);
		step_line(n);
		line_items += 1 + ((n < total) ? n : total);
	endtask

	task automatic drain_pixels();
		item_valid <= 1'b0;
		do @(posedge clk); while (pixels_pending != 0);
	endtask

	initial begin : stimulus
		int sx;
		int sy;
		int ex;
		int ey;
		int thk;
		int line_no;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		step_line(1);
		run_line(300, 300, 300, 300, 'h5a, 5, 1, 1'b0);
		run_line(10, 20, 15, 22, 'h01, 0, 1, 1'b0);
		run_line(0, 0, 2, 1, 'h00, 1, 0, 1'b0);
		run_line(1023, 1023, 1022, 1021, 'hff, 2, 0, 1'b0);
		run_line(5, 5, 8, 2, 'h33, 1, 0, 1'b0);
		run_line(10, 10, 10, 12, 'hc3, 1, 0, 1'b0);
		// restart lands while this one is still busy
		run_line(0, 1023, 1023, 0, 'ha5, 31, 0, 1'b1);

		line_no = 0;
		while (line_items < LINE_ITEMS) begin
			wait_cap = ($urandom_range(0, 5) == 0) ? 0 : 14;
			case ($urandom_range(0, 11))
				0: begin
					send_item(1'($urandom_range(0, 1)), $urandom_range(0, 1023),
						$urandom_range(0, 1023), $urandom_range(0, 1023),
						$urandom_range(0, 1023), $urandom_range(0, 255),
						$urandom_range(0, 31));
					line_items++;
				end
				1: run_line($urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 255), $urandom_range(0, 31), 0, 1'b1);
				default: begin
					sx = pick_coord();
					sy = pick_coord();
					ex = sx + $urandom_range(0, 16) - 8;
					ey = sy + $urandom_range(0, 16) - 8;
					if (ex < 0 || ex > 1023)
						ex = 2 * sx - ex;
					if (ey < 0 || ey > 1023)
						ey = 2 * sy - ey;
					if ($urandom_range(0, 11) == 0) begin
						ex = sx;
						ey = sy;
					end
					case ($urandom_range(0, 15))
						0: thk = 0;
						1: thk = $urandom_range(5, 31);
						default: thk = $urandom_range(1, 4);
					endcase
					run_line(sx, sy, ex, ey, $urandom_range(0, 255), thk,
						($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0,
						$urandom_range(0, 7) == 0);
				end
			endcase
			if (line_no == 10 || $urandom_range(0, 19) == 0)
				drain_pixels();
			line_no++;
		end

		drain_pixels();
		repeat (8) @(posedge clk);
		if (error_count == 0 && pixels_pending == 0)
			$display("tb_thick_line_pixel_generator: PASS");
		else
			$display("tb_thick_line_pixel_generator: FAIL");
		$finish;
	end

endmodule
